// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion wrappers, compiled out when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define AMGC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define AMGC_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AMGC_ASSERT(lbl, clk, rst, prop, msg)
`define AMGC_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// ----- src/amgc_pkg.sv -----
// ----------------------------------------------------------------------------
// amgc_pkg
// shared types and codes of the adjacency matrix graph engine
// ----------------------------------------------------------------------------
package amgc_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int VTX_W = 6;
  localparam int CNT_W = 7;
  localparam int OP_W = 3;
  localparam int ST_W = 2;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CNT_W-1:0] VCOUNT_RESET = 7'd64;

  localparam logic [OP_W-1:0] OP_ADD = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
  localparam logic [OP_W-1:0] OP_TEST = 3'd2;
  localparam logic [OP_W-1:0] OP_LIST_OUT = 3'd3;
  localparam logic [OP_W-1:0] OP_LIST_IN = 3'd4;
  localparam logic [OP_W-1:0] OP_COMPLETE = 3'd5;

  localparam logic [ST_W-1:0] ST_INVALID = 2'd0;
  localparam logic [ST_W-1:0] ST_NO = 2'd1;
  localparam logic [ST_W-1:0] ST_YES = 2'd2;

  typedef enum logic [2:0] {
    K_INSTANT,
    K_ADD,
    K_REMOVE,
    K_TEST,
    K_LIST_OUT,
    K_LIST_IN,
    K_COMPLETE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    logic [ST_W-1:0] status;
    logic [VTX_W-1:0] src;
    logic [VTX_W-1:0] dst;
    logic [CNT_W-1:0] count;
  } cmd_t;

  typedef struct packed {
    logic [ST_W-1:0] status;
    logic [VTX_W-1:0] neighbour;
    logic last;
  } result_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_EDGE,
    B_LOAD,
    B_SCAN,
    B_COMPLETE,
    B_FLUSH
  } back_state_t;

endpackage

// ----- src/adjacency_matrix_graph_engine_core.sv -----
// ----------------------------------------------------------------------------
// adjacency_matrix_graph_engine_core
// directed graph on an adjacency bit matrix: add, remove, test, list, complete
// ----------------------------------------------------------------------------
// Edge add, remove and test read the source row while idle and push their
// result from the edge state. A list walks one vertex per cycle while no
// result stall holds it, and the in-list and complete check read one matrix
// row per cycle through the single read port of the matrix ram. Reset
// empties the graph at once through per-row valid bits, with no clearing
// pass. Up to two operations and two results wait in the queues on either
// side.
module adjacency_matrix_graph_engine_core #(
  parameter int MAX_VERTICES = amgc_pkg::MAX_VERTICES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic [amgc_pkg::OP_W-1:0]  op,
  input  logic [amgc_pkg::VTX_W-1:0] source_vertex,
  input  logic [amgc_pkg::VTX_W-1:0] dest_vertex,
  output logic                       empty,
  input  logic                       pop,
  output logic [amgc_pkg::ST_W-1:0]  status,
  output logic [amgc_pkg::VTX_W-1:0] neighbour_vertex,
  output logic                       last,
  input  logic                       cfg_we,
  input  logic [amgc_pkg::CNT_W-1:0] cfg_wdata
);

  import amgc_pkg::*;

  logic [CNT_W-1:0] vertex_count;
  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;
  logic res_push;
  result_t res_data;
  logic res_full;
  logic [$bits(result_t)-1:0] res_raw;
  result_t res_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VCOUNT_RESET;
    end else if (cfg_we) begin
      vertex_count <= cfg_wdata;
    end
  end

  amgc_front #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .op           (op),
    .source_vertex(source_vertex),
    .dest_vertex  (dest_vertex),
    .vertex_count (vertex_count),
    .full         (full),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop)
  );

  amgc_back #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop),
    .res_push (res_push),
    .res_data (res_data),
    .res_full (res_full)
  );

  amgc_queue #(
    .WIDTH($bits(result_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_res_queue (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .wdata(res_data),
    .full (res_full),
    .pop  (pop),
    .rdata(res_raw),
    .empty(empty)
  );

  assign res_head = result_t'(res_raw);
  assign status = res_head.status;
  assign neighbour_vertex = res_head.neighbour;
  assign last = res_head.last;

endmodule

// ----- src/amgc_ram.sv -----
// ----------------------------------------------------------------------------
// amgc_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module amgc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/amgc_queue.sv -----
// ----------------------------------------------------------------------------
// amgc_queue
// small register queue with push/full and pop/empty sides
// ----------------------------------------------------------------------------
module amgc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_QW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_QW-1:0] count;
  logic do_push;
  logic do_pop;

  assign full = (count == CNT_QW'(DEPTH));
  assign empty = (count == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_QW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_QW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

// ----- src/amgc_front.sv -----
// ----------------------------------------------------------------------------
// amgc_front
// accepts operations, checks vertex bounds and queues classified commands
// ----------------------------------------------------------------------------
module amgc_front #(
  parameter int MAX_VERTICES = amgc_pkg::MAX_VERTICES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  logic [amgc_pkg::OP_W-1:0]   op,
  input  logic [amgc_pkg::VTX_W-1:0]  source_vertex,
  input  logic [amgc_pkg::VTX_W-1:0]  dest_vertex,
  input  logic [amgc_pkg::CNT_W-1:0]  vertex_count,
  output logic                        full,
  output logic                        cmd_valid,
  output amgc_pkg::cmd_t              cmd,
  input  logic                        cmd_pop
);

  import amgc_pkg::*;

  logic [CNT_W-1:0] eff_count;
  logic src_ok;
  logic dst_ok;
  cmd_t cmd_in;
  logic [$bits(cmd_t)-1:0] cmd_raw;
  logic cmdq_empty;

  assign eff_count = (vertex_count > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES)
                                                           : vertex_count;
  assign src_ok = ({1'b0, source_vertex} < eff_count);
  assign dst_ok = ({1'b0, dest_vertex} < eff_count);

  always_comb begin
    cmd_in.kind = K_INSTANT;
    cmd_in.status = ST_INVALID;
    cmd_in.src = source_vertex;
    cmd_in.dst = dest_vertex;
    cmd_in.count = eff_count;
    case (op)
      OP_ADD: begin
        if (src_ok && dst_ok) begin
          cmd_in.kind = K_ADD;
        end
      end
      OP_REMOVE: begin
        if (src_ok && dst_ok) begin
          cmd_in.kind = K_REMOVE;
        end
      end
      OP_TEST: begin
        if (src_ok && dst_ok) begin
          cmd_in.kind = K_TEST;
        end
      end
      OP_LIST_OUT: begin
        if (src_ok) begin
          cmd_in.kind = K_LIST_OUT;
        end
      end
      OP_LIST_IN: begin
        if (src_ok) begin
          cmd_in.kind = K_LIST_IN;
        end
      end
      OP_COMPLETE: begin
        // empty graph is complete without a scan
        if (eff_count == '0) begin
          cmd_in.status = ST_YES;
        end else begin
          cmd_in.kind = K_COMPLETE;
        end
      end
      default: begin
        cmd_in.kind = K_INSTANT;
      end
    endcase
  end

  amgc_queue #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .wdata(cmd_in),
    .full (full),
    .pop  (cmd_pop),
    .rdata(cmd_raw),
    .empty(cmdq_empty)
  );

  assign cmd = cmd_t'(cmd_raw);
  assign cmd_valid = !cmdq_empty;

endmodule

// ----- src/amgc_back.sv -----
// ----------------------------------------------------------------------------
// amgc_back
// executes queued commands against the adjacency matrix ram
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module amgc_back #(
  parameter int MAX_VERTICES = amgc_pkg::MAX_VERTICES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  amgc_pkg::cmd_t    cmd,
  output logic              cmd_pop,
  output logic              res_push,
  output amgc_pkg::result_t res_data,
  input  logic              res_full
);

  import amgc_pkg::*;

  localparam int IDX_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

  back_state_t state;
  back_state_t state_next;

  logic [IDX_W-1:0] j;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] s_idx;
  logic [IDX_W-1:0] d_idx;
  logic [IDX_W-1:0] pend_vtx;
  logic [IDX_W-1:0] fin_vtx;
  logic [ST_W-1:0] fin_status;
  logic pend_v;
  logic rv_q;

  logic [MAX_VERTICES-1:0] row_valid;
  logic [MAX_VERTICES-1:0] row_q;
  logic [MAX_VERTICES-1:0] low_mask;
  logic [MAX_VERTICES-1:0] low_mask_next;
  logic [MAX_VERTICES-1:0] ram_rdata;
  logic [MAX_VERTICES-1:0] rd_row;
  logic [MAX_VERTICES-1:0] onehot_j;
  logic [MAX_VERTICES-1:0] onehot_d;
  logic [MAX_VERTICES-1:0] wr_row;

  logic ram_we;
  logic edge_bit;
  logic bit_now;
  logic at_end;
  logic hit_emit;
  logic stall;
  logic row_ok;

  assign s_idx = cmd.src[IDX_W-1:0];
  assign d_idx = cmd.dst[IDX_W-1:0];

  amgc_ram #(
    .WIDTH(MAX_VERTICES),
    .DEPTH(MAX_VERTICES)
  ) u_matrix (
    .clk  (clk),
    .we   (ram_we),
    .waddr(s_idx),
    .wdata(wr_row),
    .raddr(rd_addr),
    .rdata(ram_rdata)
  );

  // rows never written read as zero
  assign rd_row = ram_rdata & {MAX_VERTICES{rv_q}};
  assign onehot_j = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << j;
  assign onehot_d = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << d_idx;
  assign edge_bit = rd_row[d_idx];
  assign bit_now = (cmd.kind == K_LIST_OUT) ? row_q[j] : rd_row[s_idx];
  assign at_end = ({{(CNT_W-IDX_W){1'b0}}, j} + CNT_W'(1)) == cmd.count;
  assign hit_emit = (state == B_SCAN) && bit_now && pend_v;
  assign stall = hit_emit && res_full;
  assign row_ok = ((rd_row | onehot_j) & low_mask) == low_mask;

  always_comb begin
    for (int k = 0; k < MAX_VERTICES; k++) begin
      low_mask_next[k] = (CNT_W'(k) < cmd.count);
    end
  end

  always_comb begin
    case (state)
      B_IDLE: begin
        rd_addr = (cmd.kind == K_LIST_IN || cmd.kind == K_COMPLETE) ? '0 : s_idx;
      end
      B_SCAN: begin
        rd_addr = stall ? j : j + IDX_W'(1);
      end
      B_COMPLETE: begin
        rd_addr = j + IDX_W'(1);
      end
      default: begin
        rd_addr = s_idx;
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (cmd_valid) begin
          case (cmd.kind)
            K_ADD, K_REMOVE, K_TEST: state_next = B_EDGE;
            K_LIST_OUT: state_next = B_LOAD;
            K_LIST_IN: state_next = B_SCAN;
            K_COMPLETE: state_next = B_COMPLETE;
            default: state_next = B_IDLE;
          endcase
        end
      end
      B_EDGE: begin
        if (!res_full) begin
          state_next = B_IDLE;
        end
      end
      B_LOAD: begin
        state_next = B_SCAN;
      end
      B_SCAN: begin
        if (!stall && at_end) begin
          state_next = B_FLUSH;
        end
      end
      B_COMPLETE: begin
        if (!row_ok || at_end) begin
          state_next = B_FLUSH;
        end
      end
      B_FLUSH: begin
        if (!res_full) begin
          state_next = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    res_push = 1'b0;
    res_data.status = ST_INVALID;
    res_data.neighbour = '0;
    res_data.last = 1'b1;
    cmd_pop = 1'b0;
    ram_we = 1'b0;
    wr_row = rd_row;
    case (state)
      B_IDLE: begin
        if (cmd_valid && cmd.kind == K_INSTANT && !res_full) begin
          res_push = 1'b1;
          res_data.status = cmd.status;
          cmd_pop = 1'b1;
        end
      end
      B_EDGE: begin
        if (!res_full) begin
          res_push = 1'b1;
          cmd_pop = 1'b1;
          case (cmd.kind)
            K_ADD: begin
              res_data.status = edge_bit ? ST_NO : ST_YES;
              ram_we = !edge_bit;
              wr_row = rd_row | onehot_d;
            end
            K_REMOVE: begin
              res_data.status = edge_bit ? ST_YES : ST_NO;
              ram_we = edge_bit;
              wr_row = rd_row & ~onehot_d;
            end
            default: begin
              res_data.status = edge_bit ? ST_YES : ST_NO;
            end
          endcase
        end
      end
      B_SCAN: begin
        // a pending neighbour is not the last one once another is found
        if (hit_emit && !res_full) begin
          res_push = 1'b1;
          res_data.status = ST_YES;
          res_data.neighbour = VTX_W'(pend_vtx);
          res_data.last = 1'b0;
        end
      end
      B_FLUSH: begin
        if (!res_full) begin
          res_push = 1'b1;
          res_data.status = fin_status;
          res_data.neighbour = VTX_W'(fin_vtx);
          cmd_pop = 1'b1;
        end
      end
      default: begin
        res_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      row_valid <= '0;
      pend_v <= 1'b0;
    end else begin
      state <= state_next;
      if (ram_we) begin
        row_valid[s_idx] <= 1'b1;
      end
      if (state == B_IDLE) begin
        pend_v <= 1'b0;
      end else if (state == B_SCAN && !stall && bit_now && !at_end) begin
        pend_v <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rv_q <= row_valid[rd_addr];
    case (state)
      B_IDLE: begin
        j <= '0;
        low_mask <= low_mask_next;
      end
      B_LOAD: begin
        row_q <= rd_row;
      end
      B_SCAN: begin
        if (!stall) begin
          if (bit_now) begin
            pend_vtx <= j;
          end
          if (at_end) begin
            fin_status <= (bit_now || pend_v) ? ST_YES : ST_NO;
            fin_vtx <= bit_now ? j : (pend_v ? pend_vtx : '0);
          end else begin
            j <= j + IDX_W'(1);
          end
        end
      end
      B_COMPLETE: begin
        fin_vtx <= '0;
        if (!row_ok) begin
          fin_status <= ST_NO;
        end else if (at_end) begin
          fin_status <= ST_YES;
        end else begin
          j <= j + IDX_W'(1);
        end
      end
      default: begin
        j <= j;
      end
    endcase
  end

  `AMGC_ASSERT(a_push_space, clk, rst, res_push |-> !res_full, "result pushed into full queue")
  `AMGC_ASSERT(a_pop_valid, clk, rst, cmd_pop |-> cmd_valid, "command popped while none waits")
  `AMGC_ASSERT(a_pop_last, clk, rst, cmd_pop |-> (res_push && res_data.last), "command retired without final result")
  `AMGC_ASSERT(a_write_result, clk, rst, ram_we |-> (res_push && state == B_EDGE), "matrix written outside an edge result")
  `AMGC_ASSERT(a_scan_range, clk, rst, (state == B_SCAN || state == B_COMPLETE) |-> (CNT_W'(j) < cmd.count), "scan index beyond vertex count")
  `AMGC_ASSERT_NR(a_reset_clear, clk, rst |=> (state == B_IDLE && row_valid == '0), "reset left state behind")

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the graph engine. A bit-matrix shadow of the
// graph predicts every result of each accepted command. Directed checks
// cover edge updates, bounds, self loops, unused codes and count
// extremes. Random traffic under several vertex counts follows, with
// complete-graph builds. The input burst and gap timing is random, and so
// is the result stall pattern.
// ----------------------------------------------------------------------------
module tb_top;
  import amgc_pkg::*;

  localparam int MAX_V = MAX_VERTICES_DEF;
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;
  localparam int SETTLE_CYCLES = 80;
  localparam int WATCHDOG_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [OP_W-1:0] op = '0;
  logic [VTX_W-1:0] source_vertex = '0;
  logic [VTX_W-1:0] dest_vertex = '0;
  logic empty;
  logic pop = 1'b0;
  logic [ST_W-1:0] status;
  logic [VTX_W-1:0] neighbour_vertex;
  logic last;
  logic cfg_we = 1'b0;
  logic [CNT_W-1:0] cfg_wdata = '0;

  // shadow of the graph and of the vertex count register
  logic [MAX_V-1:0] graph_rows [MAX_V];
  logic [CNT_W-1:0] graph_vertex_count;
  result_t pending_answers [$];
  result_t head_answer;

  int error_count = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  int stall_mode = 0;
  int stall_cycles = 0;
  int stall_tick = 0;

  adjacency_matrix_graph_engine_core u_dut (
    .clk              (clk),
    .rst              (rst),
    .push             (push),
    .full             (full),
    .op               (op),
    .source_vertex    (source_vertex),
    .dest_vertex      (dest_vertex),
    .empty            (empty),
    .pop              (pop),
    .status           (status),
    .neighbour_vertex (neighbour_vertex),
    .last             (last),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int active_vertices();
    return (graph_vertex_count > MAX_V) ? MAX_V : int'(graph_vertex_count);
  endfunction

  function automatic result_t make_answer(logic [ST_W-1:0] st, logic [VTX_W-1:0] nb,
                                          logic fin);
    result_t r;
    r.status = st;
    r.neighbour = nb;
    r.last = fin;
    return r;
  endfunction

  task automatic predict_graph_op(input logic [OP_W-1:0] code, input logic [VTX_W-1:0] src,
                                  input logic [VTX_W-1:0] dst);
    int n;
    int final_hit;
    logic hit;
    logic whole;
    n = active_vertices();
    final_hit = -1;
    whole = 1'b1;
    case (code)
      OP_ADD, OP_REMOVE, OP_TEST: begin
        if (src >= n || dst >= n) begin
          pending_answers.push_back(make_answer(ST_INVALID, '0, 1'b1));
        end else if (code == OP_ADD) begin
          pending_answers.push_back(make_answer(graph_rows[src][dst] ? ST_NO : ST_YES,
                                                '0, 1'b1));
          graph_rows[src][dst] = 1'b1;
        end else if (code == OP_REMOVE) begin
          pending_answers.push_back(make_answer(graph_rows[src][dst] ? ST_YES : ST_NO,
                                                '0, 1'b1));
          graph_rows[src][dst] = 1'b0;
        end else begin
          pending_answers.push_back(make_answer(graph_rows[src][dst] ? ST_YES : ST_NO,
                                                '0, 1'b1));
        end
      end
      OP_LIST_OUT, OP_LIST_IN: begin
        if (src >= n) begin
          pending_answers.push_back(make_answer(ST_INVALID, '0, 1'b1));
        end else begin
          for (int j = 0; j < n; j++) begin
            hit = (code == OP_LIST_OUT) ? graph_rows[src][j] : graph_rows[j][src];
            if (hit) final_hit = j;
          end
          if (final_hit < 0) begin
            pending_answers.push_back(make_answer(ST_NO, '0, 1'b1));
          end else begin
            for (int j = 0; j < n; j++) begin
              hit = (code == OP_LIST_OUT) ? graph_rows[src][j] : graph_rows[j][src];
              if (hit) begin
                pending_answers.push_back(make_answer(ST_YES, VTX_W'(j), j == final_hit));
              end
            end
          end
        end
      end
      OP_COMPLETE: begin
        for (int i = 0; i < n; i++) begin
          for (int j = 0; j < n; j++) begin
            if (i != j && !graph_rows[i][j]) whole = 1'b0;
          end
        end
        pending_answers.push_back(make_answer(whole ? ST_YES : ST_NO, '0, 1'b1));
      end
      default: begin
        pending_answers.push_back(make_answer(ST_INVALID, '0, 1'b1));
      end
    endcase
  endtask

  // one command transfer; the sender may idle between bursts of random length
  task automatic send_command(input logic [OP_W-1:0] code, input logic [VTX_W-1:0] src,
                              input logic [VTX_W-1:0] dst);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0 && push) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    push <= 1'b1;
    op <= code;
    source_vertex <= src;
    dest_vertex <= dst;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_graph_op(code, src, dst);
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    burst_left = 0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_vertex_count(input logic [CNT_W-1:0] value);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    graph_vertex_count = value;
  endtask

  task automatic send_random_command(input int n);
    int pick;
    int top;
    logic [OP_W-1:0] code;
    logic [VTX_W-1:0] src;
    logic [VTX_W-1:0] dst;
    top = (n == 0) ? 0 : n - 1;
    pick = $urandom_range(0, 99);
    if (pick < 35) code = OP_ADD;
    else if (pick < 50) code = OP_REMOVE;
    else if (pick < 65) code = OP_TEST;
    else if (pick < 75) code = OP_LIST_OUT;
    else if (pick < 85) code = OP_LIST_IN;
    else if (pick < 90) code = OP_COMPLETE;
    else code = OP_W'($urandom_range(0, 7));
    if (n == 0 || $urandom_range(0, 9) == 0) begin
      src = VTX_W'($urandom_range(0, 63));
      dst = VTX_W'($urandom_range(0, 63));
    end else begin
      src = VTX_W'($urandom_range(0, top));
      dst = VTX_W'($urandom_range(0, top));
    end
    send_command(code, src, dst);
  endtask

  task automatic build_full_graph(input int n);
    int a;
    int b;
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        if (i != j) send_command(OP_ADD, VTX_W'(i), VTX_W'(j));
      end
    end
    send_command(OP_COMPLETE, '0, '0);
    a = $urandom_range(0, n - 1);
    b = (a + $urandom_range(1, n - 1)) % n;
    send_command(OP_REMOVE, VTX_W'(a), VTX_W'(b));
    send_command(OP_COMPLETE, '0, '0);
    send_command(OP_ADD, VTX_W'(a), VTX_W'(b));
  endtask

  task automatic test_edge_ops();
    send_command(OP_ADD, 6'd0, 6'd63);
    send_command(OP_ADD, 6'd0, 6'd63);
    send_command(OP_TEST, 6'd0, 6'd63);
    send_command(OP_TEST, 6'd63, 6'd0);
    send_command(OP_REMOVE, 6'd0, 6'd63);
    send_command(OP_REMOVE, 6'd0, 6'd63);
    send_command(OP_ADD, 6'd63, 6'd63);
    send_command(OP_LIST_OUT, 6'd63, 6'd0);
    send_command(OP_LIST_IN, 6'd63, 6'd63);
    send_command(OP_LIST_OUT, 6'd5, 6'd0);
    send_command(OP_COMPLETE, 6'd0, 6'd0);
    send_command(OP_SPARE_6, 6'd1, 6'd2);
    send_command(OP_SPARE_7, 6'd63, 6'd63);
  endtask

  task automatic test_vertex_bounds();
    set_vertex_count(7'd2);
    send_command(OP_ADD, 6'd2, 6'd0);
    send_command(OP_TEST, 6'd1, 6'd5);
    send_command(OP_LIST_IN, 6'd3, 6'd0);
    send_command(OP_ADD, 6'd0, 6'd1);
    send_command(OP_ADD, 6'd1, 6'd0);
    send_command(OP_COMPLETE, 6'd0, 6'd0);
    // hidden edges above the count
    set_vertex_count(7'd1);
    send_command(OP_COMPLETE, 6'd0, 6'd0);
    send_command(OP_LIST_OUT, 6'd0, 6'd0);
    set_vertex_count(7'd0);
    send_command(OP_COMPLETE, 6'd0, 6'd0);
    send_command(OP_TEST, 6'd0, 6'd0);
    // count above the maximum saturates
    set_vertex_count(7'd127);
    send_command(OP_LIST_IN, 6'd63, 6'd0);
  endtask

  task automatic test_random_traffic();
    logic [CNT_W-1:0] counts [8];
    int n;
    counts = '{7'd64, 7'd3, 7'd16, 7'd127, 7'd4, 7'd40, 7'd2, 7'd64};
    foreach (counts[p]) begin
      set_vertex_count(counts[p]);
      n = active_vertices();
      if (n >= 2 && n <= 4) build_full_graph(n);
      repeat (9) send_random_command(n);
    end
  endtask

  // receiver stall pattern: free running, random, or sparse pops
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    if (stall_cycles == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_cycles <= $urandom_range(50, 300);
    end else begin
      stall_cycles <= stall_cycles - 1;
    end
    case (stall_mode)
      0: pop <= 1'b1;
      1: pop <= ($urandom_range(0, 1) == 1);
      default: pop <= (stall_tick % 5 == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (pending_answers.size() == 0) begin
        $error("unexpected result transfer: status %0d neighbour %0d last %0d",
               status, neighbour_vertex, last);
        error_count++;
      end else begin
        head_answer = pending_answers.pop_front();
        if (status !== head_answer.status) begin
          $error("status mismatch exp=%0d got=%0d", head_answer.status, status);
          error_count++;
        end
        if (neighbour_vertex !== head_answer.neighbour) begin
          $error("neighbour_vertex mismatch exp=%0d got=%0d", head_answer.neighbour,
                 neighbour_vertex);
          error_count++;
        end
        if (last !== head_answer.last) begin
          $error("last mismatch exp=%0d got=%0d", head_answer.last, last);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $error("watchdog expired with %0d results outstanding", pending_answers.size());
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    foreach (graph_rows[r]) graph_rows[r] = '0;
    graph_vertex_count = VCOUNT_RESET;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_edge_ops();
    test_vertex_bounds();
    test_random_traffic();
    wait_idle();
    if (pending_answers.size() != 0) begin
      $error("%0d expected results never arrived", pending_answers.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- adjacency_matrix_graph_engine_core.f -----
+incdir+src
src/amgc_pkg.sv
src/amgc_ram.sv
src/amgc_queue.sv
src/amgc_front.sv
src/amgc_back.sv
src/adjacency_matrix_graph_engine_core.sv
sim/tb_top.sv
